// ===== sv/pts_pkg.sv =====
package pts_pkg;

    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    // four terms of at most 2^62 each fit with margin
    localparam int ACC_W      = 66;
    localparam int QUO_W      = 32;
    localparam int REM_W      = ACC_W + QUO_W + 1;
    localparam int MAT_N      = 4;
    localparam int REG_N      = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [QUO_W-1:0] SAT_POS = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] SAT_NEG = {1'b1, {(QUO_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef coord_t [MAT_N-1:0][MAT_N-1:0] mat_t;

    // summed row vector times matrix, handed to the divider
    typedef struct packed {
        logic                   valid;
        acc_t [MAT_N-1:0]       acc;
    } acc_beat_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             ovf;
        logic             neg;
    } div_lane_t;

endpackage

// ===== sv/pts_ifs.sv =====
interface pts_point_if import pts_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;

    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface pts_screen_if import pts_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t screen_x;
    coord_t screen_y;
    coord_t screen_depth;
    logic   w_zero;

    modport source (output valid, output screen_x, output screen_y, output screen_depth,
                    output w_zero, input ready);
    modport sink   (input valid, input screen_x, input screen_y, input screen_depth,
                    input w_zero, output ready);
endinterface

// ===== sv/pts_transform.sv =====
module pts_transform import pts_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  mat_t      mat,
    input  logic      in_valid,
    output logic      in_ready,
    input  coord_t    px,
    input  coord_t    py,
    input  coord_t    pz,
    output acc_beat_t ds,
    input  logic      ds_ready
);

    logic [2:0] v_reg;
    logic [2:0] en;

    coord_t pt [3];

    logic signed [PROD_W-1:0] prod_reg [3][MAT_N];
    acc_t                     cterm_reg [MAT_N];
    acc_t                     part_reg [2][MAT_N];
    acc_t                     acc_reg [MAT_N];

    assign pt[0] = px;
    assign pt[1] = py;
    assign pt[2] = pz;

    assign en[2] = !v_reg[2] || ds_ready;
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    // products, then pair sums, then the full sum
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < MAT_N; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[i][j] <= PROD_W'($signed(pt[i])) * PROD_W'($signed(mat[i][j]));
                end
                cterm_reg[j] <= ACC_W'($signed(mat[3][j])) <<< FRAC_BITS;
            end
        end
        if (en[1])
        begin
            for (int j = 0; j < MAT_N; j++)
            begin
                part_reg[0][j] <= ACC_W'(prod_reg[0][j]) + ACC_W'(prod_reg[1][j]);
                part_reg[1][j] <= ACC_W'(prod_reg[2][j]) + cterm_reg[j];
            end
        end
        if (en[2])
        begin
            for (int j = 0; j < MAT_N; j++)
            begin
                acc_reg[j] <= part_reg[0][j] + part_reg[1][j];
            end
        end
    end

    always_comb
    begin
        ds.valid = v_reg[2];
        for (int j = 0; j < MAT_N; j++)
        begin
            ds.acc[j] = acc_reg[j];
        end
    end

endmodule

// ===== sv/pts_divider.sv =====
module pts_divider import pts_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  acc_beat_t us,
    output logic      us_ready,
    pts_screen_if.source screen
);

    // stage 0 magnitudes, stages 1..QUO_W+1 lanes, last stage result
    localparam int NS = QUO_W + 3;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    logic [ACC_W-1:0] abs_reg [MAT_N];
    logic [2:0]       neg_reg;
    logic             wz0_reg;

    div_lane_t        lane_reg [QUO_W+1][3];
    logic [ACC_W-1:0] den_reg [QUO_W+1];
    logic             wz_reg [QUO_W+1];

    coord_t res_reg [3];
    logic   wz_out_reg;

    assign en[NS-1] = !v_reg[NS-1] || screen.ready;
    for (genvar k = 0; k < NS - 1; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end
    assign us_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= (k == 0) ? us.valid : v_reg[k-1];
                end
            end
        end
    end

    // sign and magnitude split
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < MAT_N; j++)
            begin
                abs_reg[j] <= us.acc[j][ACC_W-1] ? ACC_W'(-us.acc[j]) : ACC_W'(us.acc[j]);
            end
            for (int j = 0; j < 3; j++)
            begin
                neg_reg[j] <= us.acc[j][ACC_W-1] ^ us.acc[3][ACC_W-1];
            end
            wz0_reg <= (us.acc[3] == '0);
        end
    end

    // scale numerator, catch quotients of 2^32 and more up front
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int j = 0; j < 3; j++)
            begin
                lane_reg[0][j].rem <= REM_W'(abs_reg[j]) << FRAC_BITS;
                lane_reg[0][j].ovf <= (REM_W'(abs_reg[j]) << FRAC_BITS)
                                      >= (REM_W'(abs_reg[3]) << QUO_W);
                lane_reg[0][j].quo <= '0;
                lane_reg[0][j].neg <= neg_reg[j];
            end
            den_reg[0] <= abs_reg[3];
            wz_reg[0]  <= wz0_reg;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_iter
        localparam int BIT = QUO_W - 1 - i;
        logic [REM_W-1:0] dsh;
        div_lane_t        nxt [3];

        assign dsh = REM_W'(den_reg[i]) << BIT;

        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                nxt[j] = lane_reg[i][j];
                if (lane_reg[i][j].rem >= dsh)
                begin
                    nxt[j].rem      = lane_reg[i][j].rem - dsh;
                    nxt[j].quo[BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[i+2])
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lane_reg[i+1][j] <= nxt[j];
                end
                den_reg[i+1] <= den_reg[i];
                wz_reg[i+1]  <= wz_reg[i];
            end
        end
    end

    // sign, saturation and the zero divisor case
    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (wz_reg[QUO_W])
                begin
                    res_reg[j] <= '0;
                end
                else if (lane_reg[QUO_W][j].neg)
                begin
                    if (lane_reg[QUO_W][j].ovf || lane_reg[QUO_W][j].quo > SAT_NEG)
                    begin
                        res_reg[j] <= SAT_NEG;
                    end
                    else
                    begin
                        res_reg[j] <= -lane_reg[QUO_W][j].quo;
                    end
                end
                else if (lane_reg[QUO_W][j].ovf || lane_reg[QUO_W][j].quo[QUO_W-1])
                begin
                    res_reg[j] <= SAT_POS;
                end
                else
                begin
                    res_reg[j] <= lane_reg[QUO_W][j].quo;
                end
            end
            wz_out_reg <= wz_reg[QUO_W];
        end
    end

    assign screen.valid        = v_reg[NS-1];
    assign screen.screen_x     = res_reg[0];
    assign screen.screen_y     = res_reg[1];
    assign screen.screen_depth = res_reg[2];
    assign screen.w_zero       = wz_out_reg;

    a_wz_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        screen.valid && screen.w_zero |->
            screen.screen_x == '0 && screen.screen_y == '0 && screen.screen_depth == '0)
        else $error("w_zero result with nonzero coordinates");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[1] && !wz_reg[0] |-> den_reg[0] != '0)
        else $error("zero divisor not flagged");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QUO_W+1] && !wz_reg[QUO_W] && !lane_reg[QUO_W][0].ovf |->
            lane_reg[QUO_W][0].rem < REM_W'(den_reg[QUO_W]))
        else $error("final remainder not below divisor");

endmodule

// ===== sv/project_point_to_screen.sv =====
// channel   dir  payload                                         beat when
// point     in   point_x, point_y, point_z (signed Q.FRAC_BITS)  point.valid && point.ready
// screen    out  screen_x, screen_y, screen_depth, w_zero        screen.valid && screen.ready
// cfg       in   cfg_index (4 b), cfg_wdata (64 b)               cfg_we
//
// one beat accepted per cycle while the output is not stalled; the stages are multiply and sum,
// then sign split and scaling, then the one-bit-per-stage divider, then output
// throughput is set by the divider pipeline, one restoring step per stage
// reset clears all valid bits and loads the identity matrix; no clearing pass
// each stage holds when its successor is full and stalled, bubbles close up
module project_point_to_screen import pts_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    pts_point_if.sink             point,
    pts_screen_if.source          screen
);

    localparam coord_t FX_ONE = coord_t'(1) << FRAC_BITS;

    mat_t       mat_reg;
    logic [1:0] cfg_row;
    logic [1:0] cfg_col;
    acc_beat_t  acc_beat;
    logic       acc_ready;

    // register index: bits [2:1] pick the row, bit 0 the column pair
    assign cfg_row = cfg_index[2:1];
    assign cfg_col = {cfg_index[0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAT_N; r++)
            begin
                for (int c = 0; c < MAT_N; c++)
                begin
                    mat_reg[r][c] <= (r == c) ? FX_ONE : '0;
                end
            end
        end
        else if (cfg_we && cfg_index < CFG_IDX_W'(REG_N))
        begin
            // writes past the last register are dropped
            mat_reg[cfg_row][cfg_col]      <= cfg_wdata[COORD_W-1:0];
            mat_reg[cfg_row][cfg_col+2'd1] <= cfg_wdata[CFG_DATA_W-1:COORD_W];
        end
    end

    // row vector times matrix
    pts_transform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_transform (
        .clk      (clk),
        .rst_n    (rst_n),
        .mat      (mat_reg),
        .in_valid (point.valid),
        .in_ready (point.ready),
        .px       (point.point_x),
        .py       (point.point_y),
        .pz       (point.point_z),
        .ds       (acc_beat),
        .ds_ready (acc_ready)
    );

    // perspective divide with saturation
    pts_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .us       (acc_beat),
        .us_ready (acc_ready),
        .screen   (screen)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pts_pkg::*;

    localparam int  FRAC        = 16;
    localparam int  DRAIN_WAIT  = 45;       // pipeline is 38 deep, with margin
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  RAND_POINTS = 1050;
    localparam int  PHASE_N     = 3;
    localparam logic [31:0] ONE    = 32'h0001_0000;
    localparam logic [31:0] NEG1   = 32'hFFFF_0000;
    localparam logic [31:0] TWO    = 32'h0002_0000;

    // register indexes, in the order of the register map
    typedef enum logic [CFG_IDX_W-1:0] {
        R0_C01 = 4'd0, R0_C23 = 4'd1, R1_C01 = 4'd2, R1_C23 = 4'd3,
        R2_C01 = 4'd4, R2_C23 = 4'd5, R3_C01 = 4'd6, R3_C23 = 4'd7
    } mat_reg_e;

    // matrix set-ups used by the directed table
    typedef enum {MX_IDENT, MX_WZERO, MX_TINYW, MX_NEGW, MX_PERSP} matrix_setup_e;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t sd;
        logic   wz;
    } screen_t;

    typedef struct {
        matrix_setup_e setup;
        coord_t        px;
        coord_t        py;
        coord_t        pz;
        logic          known;
        screen_t       res;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    pts_point_if  point_ch ();
    pts_screen_if screen_ch ();

    project_point_to_screen #(.FRAC_BITS(FRAC)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .point     (point_ch),
        .screen    (screen_ch)
    );

    // bench copy of the matrix, kept in step with every register write
    coord_t  mtx [MAT_N][MAT_N];
    screen_t pending_screens [$];
    int      send_idle;
    int      recv_idle;
    int      errors;
    int      cycles = 0;
    directed_row_t dir_rows [20];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung pipeline or a lost beat ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycles, pending_screens.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // row vector (x,y,z,1) times the matrix, then divide by w,
    // truncated toward zero and clamped to 32 bits
    function automatic screen_t predict_screen(coord_t px, coord_t py, coord_t pz);
        logic signed [127:0] acc [MAT_N];
        logic signed [127:0] ex, ey, ez, q;
        coord_t  lane [3];
        screen_t r;
        ex = px;
        ey = py;
        ez = pz;
        for (int j = 0; j < MAT_N; j++)
        begin
            acc[j] = (128'(signed'(mtx[3][j])) <<< FRAC)
                   + ex * 128'(signed'(mtx[0][j]))
                   + ey * 128'(signed'(mtx[1][j]))
                   + ez * 128'(signed'(mtx[2][j]));
        end
        if (acc[3] == 0)
        begin
            r = '{sx: '0, sy: '0, sd: '0, wz: 1'b1};
            return r;
        end
        for (int j = 0; j < 3; j++)
        begin
            q = (acc[j] <<< FRAC) / acc[3];
            if (q > 128'sh7FFF_FFFF)
                lane[j] = SAT_POS;
            else if (q < -128'sh8000_0000)
                lane[j] = SAT_NEG;
            else
                lane[j] = q[31:0];
        end
        r = '{sx: lane[0], sy: lane[1], sd: lane[2], wz: 1'b0};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    // a register write holds cfg_we high; the caller lowers it after the batch
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx < REG_N)
        begin
            mtx[idx >> 1][(idx & 1) * 2]     = data[31:0];
            mtx[idx >> 1][(idx & 1) * 2 + 1] = data[63:32];
        end
    endtask

    // block is idle before any write: all beats back, plus the pipeline depth
    task automatic drain_pipeline();
        while (pending_screens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic load_matrix(logic [CFG_DATA_W-1:0] regs [REG_N]);
        drain_pipeline();
        for (int i = 0; i < REG_N; i++)
            write_reg(mat_reg_e'(i), regs[i]);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setup(matrix_setup_e setup);
        logic [CFG_DATA_W-1:0] regs [REG_N];
        // identity first, then the set-up's own changes
        regs[R0_C01] = {32'h0, ONE};
        regs[R0_C23] = '0;
        regs[R1_C01] = {ONE, 32'h0};
        regs[R1_C23] = '0;
        regs[R2_C01] = '0;
        regs[R2_C23] = {32'h0, ONE};
        regs[R3_C01] = '0;
        regs[R3_C23] = {ONE, 32'h0};
        case (setup)
            MX_WZERO: regs[R3_C23] = '0;
            MX_TINYW: regs[R3_C23] = {32'h1, 32'h0};
            MX_NEGW:  regs[R3_C23] = {NEG1, 32'h0};
            MX_PERSP:
            begin
                // w taken from z plus a half, scaled x, viewport offset
                regs[R0_C01] = {32'h0, TWO};
                regs[R2_C23] = {ONE, ONE};
                regs[R3_C01] = {32'h0005_0000, 32'h0003_0000};
                regs[R3_C23] = {32'h0000_8000, 32'h0};
            end
            default: ;
        endcase
        load_matrix(regs);
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return ONE;
            2:       return NEG1;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5, 6:    return 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_matrix();
        logic [CFG_DATA_W-1:0] regs [REG_N];
        int mode;
        mode = $urandom_range(7);
        for (int i = 0; i < REG_N; i++)
        begin
            case (mode)
                0:       regs[i] = {2{32'h7FFF_FFFF}};
                1:       regs[i] = {2{32'h8000_0000}};
                default: regs[i] = {rand_entry(), rand_entry()};
            endcase
        end
        load_matrix(regs);
        // indexes past the map must leave the matrix alone
        if ($urandom_range(2) == 0)
        begin
            write_reg(4'($urandom_range(REG_N, 15)), {$urandom, $urandom});
            cfg_we <= 1'b0;
        end
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
            7:          return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            8:          return 32'($urandom_range(4)) - 32'd2;
            default:    return (32'($urandom_range(64)) - 32'd32) << FRAC;
        endcase
    endfunction

    // one point beat; valid stays up across back-to-back beats
    task automatic send_point(coord_t px, coord_t py, coord_t pz);
        while ($urandom_range(99) < send_idle)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.point_x <= px;
        point_ch.point_y <= py;
        point_ch.point_z <= pz;
        do
            @(posedge clk);
        while (!point_ch.ready);
        pending_screens.push_back(predict_screen(px, py, pz));
    endtask

    // receiver stalls at random
    always @(posedge clk)
    begin
        if (!rst_n)
            screen_ch.ready <= 1'b0;
        else
            screen_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // screen beats against the oldest expectation, field by field
    always @(posedge clk)
    begin
        screen_t want;
        if (rst_n && screen_ch.valid && screen_ch.ready)
        begin
            if (pending_screens.size() == 0)
            begin
                $display("screen beat with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_screens.pop_front();
                if (screen_ch.screen_x !== want.sx)
                    report_mismatch("screen_x", screen_ch.screen_x, want.sx);
                if (screen_ch.screen_y !== want.sy)
                    report_mismatch("screen_y", screen_ch.screen_y, want.sy);
                if (screen_ch.screen_depth !== want.sd)
                    report_mismatch("screen_depth", screen_ch.screen_depth, want.sd);
                if (screen_ch.w_zero !== want.wz)
                    report_mismatch("w_zero", 32'(screen_ch.w_zero), 32'(want.wz));
            end
        end
    end

    initial
    begin
        matrix_setup_e cur_setup;
        int            per_phase;
        errors    = 0;
        send_idle = 7;
        recv_idle = 52;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        point_ch.valid   = 1'b0;
        point_ch.point_x = '0;
        point_ch.point_y = '0;
        point_ch.point_z = '0;
        // identity after reset
        for (int r = 0; r < MAT_N; r++)
            for (int c = 0; c < MAT_N; c++)
                mtx[r][c] = (r == c) ? ONE : 32'h0;

        // directed table; known rows are checked against the typed value as well
        dir_rows = '{
            // identity straight out of reset: points pass through unchanged
            '{MX_IDENT, 32'sh0, 32'sh0, 32'sh0, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b0}},
            '{MX_IDENT, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 1'b1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0}},
            '{MX_IDENT, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1, 1'b1,
              '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
            '{MX_IDENT, 32'sh1234_5678, -32'sh0000_8000, 32'sh0000_0001, 1'b1,
              '{32'h1234_5678, 32'hFFFF_8000, 32'h0000_0001, 1'b0}},
            // w forced to zero: outputs cleared and flag raised
            '{MX_WZERO, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b1,
              '{32'h0, 32'h0, 32'h0, 1'b1}},
            '{MX_WZERO, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1,
              '{32'h0, 32'h0, 32'h0, 1'b1}},
            // w of one lsb: everything scales by 2^16 and clamps
            '{MX_TINYW, 32'sh1, -32'sh1, 32'sh0, 1'b1,
              '{32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b0}},
            '{MX_TINYW, 32'sh8000, -32'sh8000, 32'sh7FFF_FFFF, 1'b1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0}},
            '{MX_TINYW, 32'sh8000_0000, -32'sh8001, 32'sh7FFF, 1'b1,
              '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_0000, 1'b0}},
            // negative w flips signs; the most negative point clamps high
            '{MX_NEGW, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000, 1'b1,
              '{32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_0000, 1'b0}},
            '{MX_NEGW, -32'sh1, 32'sh0, 32'sh1, 1'b1,
              '{32'h1, 32'h0, 32'hFFFF_FFFF, 1'b0}},
            // perspective: w follows z, so z of minus half a unit gives w zero
            '{MX_PERSP, 32'sh0001_0000, 32'sh0001_0000, -32'sh0000_8000, 1'b1,
              '{32'h0, 32'h0, 32'h0, 1'b1}},
            '{MX_PERSP, 32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 1'b0, '0},
            '{MX_PERSP, -32'sh0004_0000, 32'sh0003_8000, 32'sh0010_0000, 1'b0, '0},
            '{MX_PERSP, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001, 1'b0, '0},
            '{MX_PERSP, 32'sh0000_0003, -32'sh0000_0007, -32'sh0000_8001, 1'b0, '0},
            '{MX_PERSP, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, '0},
            '{MX_PERSP, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, '0},
            '{MX_PERSP, 32'sh5555_5555, 32'shAAAA_AAAA, -32'sh0000_7FFF, 1'b0, '0},
            '{MX_PERSP, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0, '0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part; the first rows run on the reset matrix untouched
        cur_setup = MX_IDENT;
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].setup != cur_setup)
            begin
                point_ch.valid <= 1'b0;
                cur_setup = dir_rows[k].setup;
                apply_setup(cur_setup);
            end
            if (dir_rows[k].known && predict_screen(dir_rows[k].px, dir_rows[k].py,
                                                    dir_rows[k].pz) !== dir_rows[k].res)
            begin
                $display("directed row %0d disagrees with its typed result", k);
                errors++;
            end
            send_point(dir_rows[k].px, dir_rows[k].py, dir_rows[k].pz);
        end
        point_ch.valid <= 1'b0;

        // random part in three idling phases, new matrix every so often
        per_phase = RAND_POINTS / PHASE_N;
        for (int ph = 0; ph < PHASE_N; ph++)
        begin
            case (ph)
                0:       begin send_idle = 7;  recv_idle = 52; end
                1:       begin send_idle = 52; recv_idle = 7;  end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            for (int n = 0; n < per_phase; n++)
            begin
                if (n % 70 == 0)
                begin
                    point_ch.valid <= 1'b0;
                    random_matrix();
                end
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
            point_ch.valid <= 1'b0;
        end

        drain_pipeline();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
